// ===== src/phv_pkg.sv =====
// ----------------------------------------------------------------------------
// phv_pkg
// shared types, codes and the protocol name table for the handshake validator
// ----------------------------------------------------------------------------
package phv_pkg;

	localparam int IDLE_COUNTER_BITS = 16;
	localparam int LIMIT_BITS        = 16;
	localparam int IDLE_CMP_BITS     = (IDLE_COUNTER_BITS > LIMIT_BITS) ?
	                                   IDLE_COUNTER_BITS : LIMIT_BITS;

	localparam int ID_BITS   = 160;
	localparam int POS_BITS  = 7;

	localparam logic [POS_BITS-1:0] NAME_LEN   = 7'd19;
	localparam logic [POS_BITS-1:0] HASH_START = 7'd28;
	localparam logic [POS_BITS-1:0] ID_START   = 7'd48;
	localparam logic [POS_BITS-1:0] LAST_POS   = 7'd67;

	typedef enum logic [2:0] {
		VERDICT_OK       = 3'd0,
		VERDICT_BAD_LEN  = 3'd1,
		VERDICT_BAD_NAME = 3'd2,
		VERDICT_BAD_HASH = 3'd3,
		VERDICT_SELF_ID  = 3'd4,
		VERDICT_TIMEOUT  = 3'd5,
		VERDICT_ABORTED  = 3'd6
	} verdict_t;

	typedef enum logic [1:0] {
		REQ_BYTE  = 2'd0,
		REQ_TICK  = 2'd1,
		REQ_ABORT = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		CFG_HASH0    = 3'd0,
		CFG_HASH1    = 3'd1,
		CFG_HASH2    = 3'd2,
		CFG_ID0      = 3'd3,
		CFG_ID1      = 3'd4,
		CFG_ID2      = 3'd5,
		CFG_IDLE_LIM = 3'd6,
		CFG_UNUSED   = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [ID_BITS-1:0]    torrent_hash;
		logic [ID_BITS-1:0]    local_id;
		logic [LIMIT_BITS-1:0] idle_limit;
	} cfg_t;

	typedef struct packed {
		verdict_t           verdict;
		logic [63:0]        reserved;
		logic [ID_BITS-1:0] peer_id;
	} q_entry_t;

	// byte i of a 20-byte value, byte 0 in the top bits
	function automatic logic [7:0] id_byte(logic [ID_BITS-1:0] v, logic [4:0] i);
		logic [4:0] k;
		k = (i > 5'd19) ? 5'd19 : i;
		return v[8*(19 - int'(k)) +: 8];
	endfunction

	// expected protocol name, position 1..19
	function automatic logic [7:0] name_char(logic [4:0] i);
		logic [7:0] c;
		case (i)
			5'd1:    c = "B";
			5'd2:    c = "i";
			5'd3:    c = "t";
			5'd4:    c = "T";
			5'd5:    c = "o";
			5'd6:    c = "r";
			5'd7:    c = "r";
			5'd8:    c = "e";
			5'd9:    c = "n";
			5'd10:   c = "t";
			5'd11:   c = " ";
			5'd12:   c = "p";
			5'd13:   c = "r";
			5'd14:   c = "o";
			5'd15:   c = "t";
			5'd16:   c = "o";
			5'd17:   c = "c";
			5'd18:   c = "o";
			5'd19:   c = "l";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== src/peer_handshake_validator_unit.sv =====
// ----------------------------------------------------------------------------
// peer_handshake_validator_unit
// peer handshake checker, one received byte per transaction
// ----------------------------------------------------------------------------
// Takes one transaction per clock while not stalled: a received byte, a time
// tick or an abort. The front stage tracks the 68-byte handshake (length,
// protocol name, reserved bytes, info hash, remote peer id) and the idle
// tick counter. Each verdict goes into a two-entry queue; the back stage
// turns a pass into three results (one per peer id word) and a failure into
// one, through an output register, one result per cycle while out_stall is
// low. in_stall rises only when the queue holds two verdicts, so the input
// runs at one transaction per cycle until the queue fills (output stall or
// verdicts close behind a pass). Configuration writes are always ready and
// take effect on the next cycle; write them only while the block is idle.
// ----------------------------------------------------------------------------
module peer_handshake_validator_unit (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  rx_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  verdict,
	output logic [63:0] reserved_bits,
	output logic [1:0]  word_index,
	output logic [63:0] peer_id_word,
	output logic        last,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	phv_pkg::cfg_t     cfg_q;
	phv_pkg::q_entry_t push_data, head;
	logic              push, pop, q_empty, q_full, accept;

	// register file, writes always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.torrent_hash <= '0;
			cfg_q.local_id     <= '0;
			cfg_q.idle_limit   <= 16'd30000;
		end else if (cfg_valid) begin
			case (phv_pkg::cfg_idx_t'(cfg_index))
				phv_pkg::CFG_HASH0:    cfg_q.torrent_hash[159:96] <= cfg_data;
				phv_pkg::CFG_HASH1:    cfg_q.torrent_hash[95:32]  <= cfg_data;
				phv_pkg::CFG_HASH2:    cfg_q.torrent_hash[31:0]   <= cfg_data[31:0];
				phv_pkg::CFG_ID0:      cfg_q.local_id[159:96]     <= cfg_data;
				phv_pkg::CFG_ID1:      cfg_q.local_id[95:32]      <= cfg_data;
				phv_pkg::CFG_ID2:      cfg_q.local_id[31:0]       <= cfg_data[31:0];
				phv_pkg::CFG_IDLE_LIM: cfg_q.idle_limit           <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// front only stalls when no queue slot is free
	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	phv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req_type (req_type),
		.rx_byte  (rx_byte),
		.cfg      (cfg_q),
		.push     (push),
		.entry    (push_data)
	);

	phv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	phv_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.empty         (q_empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.verdict       (verdict),
		.reserved_bits (reserved_bits),
		.word_index    (word_index),
		.peer_id_word  (peer_id_word),
		.last          (last)
	);

endmodule

// ===== src/phv_front.sv =====
// ----------------------------------------------------------------------------
// phv_front
// per-item handshake tracking: position, checks, idle timer, verdict push
// ----------------------------------------------------------------------------
module phv_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [1:0]        req_type,
	input  logic [7:0]        rx_byte,
	input  phv_pkg::cfg_t     cfg,
	output logic              push,
	output phv_pkg::q_entry_t entry
);

	logic [phv_pkg::POS_BITS-1:0]          pos_q, pos_d;
	phv_pkg::verdict_t                     err_q, err_d;
	logic [63:0]                           res_q, res_d;
	logic [phv_pkg::ID_BITS-1:0]           id_q, id_d;
	logic                                  eq_q, eq_d;
	logic [phv_pkg::IDLE_COUNTER_BITS-1:0] idle_q, idle_d, idle_inc;
	logic                                  restart;
	logic [4:0]                            hash_off, id_off;
	logic [7:0]                            hash_exp, id_exp, name_exp;

	assign hash_off = 5'(pos_q - phv_pkg::HASH_START);
	assign id_off   = 5'(pos_q - phv_pkg::ID_START);
	assign hash_exp = phv_pkg::id_byte(cfg.torrent_hash, hash_off);
	assign id_exp   = phv_pkg::id_byte(cfg.local_id, id_off);
	assign name_exp = phv_pkg::name_char(pos_q[4:0]);
	assign idle_inc = (idle_q == '1) ? idle_q : idle_q + 1'b1;

	always_comb begin
		pos_d         = pos_q;
		err_d         = err_q;
		res_d         = res_q;
		id_d          = id_q;
		eq_d          = eq_q;
		idle_d        = idle_q;
		restart       = 1'b0;
		push          = 1'b0;
		entry.verdict = phv_pkg::VERDICT_OK;
		entry.reserved = res_q;
		entry.peer_id = id_q;
		if (accept) begin
			case (phv_pkg::req_t'(req_type))
				phv_pkg::REQ_ABORT: begin
					push          = 1'b1;
					entry.verdict = phv_pkg::VERDICT_ABORTED;
					restart       = 1'b1;
				end
				phv_pkg::REQ_TICK: begin
					idle_d = idle_inc;
					if (phv_pkg::IDLE_CMP_BITS'(idle_inc) >=
					    phv_pkg::IDLE_CMP_BITS'(cfg.idle_limit)) begin
						push          = 1'b1;
						entry.verdict = phv_pkg::VERDICT_TIMEOUT;
						restart       = 1'b1;
					end
				end
				phv_pkg::REQ_BYTE: begin
					idle_d = '0;
					if (pos_q == '0) begin
						if (rx_byte != 8'(phv_pkg::NAME_LEN) &&
						    err_q == phv_pkg::VERDICT_OK)
							err_d = phv_pkg::VERDICT_BAD_LEN;
					end else if (pos_q <= phv_pkg::NAME_LEN) begin
						if (rx_byte != name_exp && err_q == phv_pkg::VERDICT_OK)
							err_d = phv_pkg::VERDICT_BAD_NAME;
					end else if (pos_q < phv_pkg::HASH_START) begin
						res_d = {res_q[55:0], rx_byte};
					end else if (pos_q < phv_pkg::ID_START) begin
						if (rx_byte != hash_exp && err_q == phv_pkg::VERDICT_OK)
							err_d = phv_pkg::VERDICT_BAD_HASH;
					end else begin
						id_d = {id_q[phv_pkg::ID_BITS-9:0], rx_byte};
						if (rx_byte != id_exp)
							eq_d = 1'b0;
					end
					pos_d = pos_q + 1'b1;
					if (pos_q >= phv_pkg::LAST_POS) begin
						// handshake complete: first failing check wins
						push           = 1'b1;
						restart        = 1'b1;
						entry.reserved = res_d;
						entry.peer_id  = id_d;
						if (err_d != phv_pkg::VERDICT_OK)
							entry.verdict = err_d;
						else if (eq_d)
							entry.verdict = phv_pkg::VERDICT_SELF_ID;
						else
							entry.verdict = phv_pkg::VERDICT_OK;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			err_q  <= phv_pkg::VERDICT_OK;
			res_q  <= '0;
			eq_q   <= 1'b1;
			idle_q <= '0;
		end else if (restart) begin
			pos_q  <= '0;
			err_q  <= phv_pkg::VERDICT_OK;
			res_q  <= '0;
			eq_q   <= 1'b1;
			idle_q <= '0;
		end else begin
			pos_q  <= pos_d;
			err_q  <= err_d;
			res_q  <= res_d;
			eq_q   <= eq_d;
			idle_q <= idle_d;
		end
	end

	// remote id needs no reset, every byte is rewritten before use
	always_ff @(posedge clk) begin
		id_q <= id_d;
	end

endmodule

// ===== src/phv_queue.sv =====
// ----------------------------------------------------------------------------
// phv_queue
// two-entry verdict queue between front and back
// ----------------------------------------------------------------------------
module phv_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  phv_pkg::q_entry_t push_data,
	input  logic              pop,
	output phv_pkg::q_entry_t head,
	output logic              empty,
	output logic              full
);

	phv_pkg::q_entry_t mem_q [2];
	logic              wr_ptr_q, rd_ptr_q;
	logic [1:0]        count_q;

	assign empty = (count_q == 2'd0);
	assign full  = (count_q == 2'd2);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/phv_back.sv =====
// ----------------------------------------------------------------------------
// phv_back
// expands queued verdicts into results behind an output register
// ----------------------------------------------------------------------------
module phv_back (
	input  logic              clk,
	input  logic              arst_n,
	input  phv_pkg::q_entry_t head,
	input  logic              empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        verdict,
	output logic [63:0]       reserved_bits,
	output logic [1:0]        word_index,
	output logic [63:0]       peer_id_word,
	output logic              last
);

	logic        valid_q;
	logic [1:0]  word_q;
	logic        load, pass, final_word;
	logic [63:0] word_sel;

	assign load       = !empty && (!valid_q || !out_stall);
	assign pass       = (head.verdict == phv_pkg::VERDICT_OK);
	assign final_word = !pass || (word_q == 2'd2);
	assign pop        = load && final_word;
	assign out_valid  = valid_q;

	always_comb begin
		case (word_q)
			2'd0:    word_sel = head.peer_id[159:96];
			2'd1:    word_sel = head.peer_id[95:32];
			default: word_sel = {32'h0, head.peer_id[31:0]};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			word_q  <= '0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (!out_stall)
				valid_q <= 1'b0;
			if (load)
				word_q <= final_word ? 2'd0 : word_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			verdict       <= head.verdict;
			reserved_bits <= pass ? head.reserved : 64'h0;
			word_index    <= pass ? word_q : 2'd0;
			peer_id_word  <= pass ? word_sel : 64'h0;
			last          <= final_word;
		end
	end

endmodule
